### src/tdpt_pkg.sv
// Shared widths and control types for the trial-division prime test core.
`timescale 1ns / 1ps
`default_nettype none

package tdpt_pkg;

    // Width of the candidate value, two's complement
    localparam int VALUE_WIDTH = 32;
    // Width of the reported divisor counter
    localparam int CNT_W = VALUE_WIDTH - 1;
    // Width of the running divisor square
    localparam int SQ_W = VALUE_WIDTH + 1;
    // Width of the bit counter in the remainder unit
    localparam int BIT_W = $clog2(VALUE_WIDTH);

    // Smallest trial divisor and its square
    localparam logic [VALUE_WIDTH-1:0] FIRST_DIVISOR = VALUE_WIDTH'(2);
    localparam logic [SQ_W-1:0]        FIRST_SQUARE  = SQ_W'(4);

    // Request from the sequencer to the remainder unit
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    // Status from the remainder unit to the sequencer
    typedef struct packed {
        logic done;
        logic rem_zero;
    } div_stat_t;

endpackage

`default_nettype wire

### src/tdpt_if.sv
// Valid/ready channel interfaces for candidates and results.
`timescale 1ns / 1ps
`default_nettype none

interface tdpt_cand_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [tdpt_pkg::VALUE_WIDTH-1:0]    candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

interface tdpt_res_if;
    logic                           valid;
    logic                           ready;
    logic                           no_divisor;
    logic [tdpt_pkg::CNT_W-1:0]     final_counter;

    modport source (output valid, output no_divisor, output final_counter, input ready);
    modport sink   (input valid, input no_divisor, input final_counter, output ready);
endinterface

`default_nettype wire

### src/trial_division_prime_test_core.sv
// Top level: trial-division prime test sequencer with result register.
//
// Usage:
//   cand carries one signed candidate per beat; res returns one beat per
//   candidate with no_divisor and final_counter.
//   Candidates of 2 or less (negatives included) go from accept straight to
//   the finish state and then the result register. Otherwise divisors
//   d = 2, 3, ... are tried while d*d <= candidate; each trial is a check,
//   one bit-serial remainder step per dividend bit and a step to see the
//   remainder done. A prime near 2^31 needs about 46340 trials, a composite
//   stops at its smallest factor. The remainder unit is the one shared loop.
//   One candidate is worked on at a time; a new beat is taken as soon as
//   the sequencer is idle, which it is once the result loads, even while the
//   previous result waits in the output register.
//   When the receiver stalls, the result holds in the output register and a
//   finished search waits until that register frees.
//   Reset clears the sequencer to idle and drops any pending result; no
//   clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module trial_division_prime_test_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tdpt_cand_if.sink   cand,
    tdpt_res_if.source  res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIVIDE,
        S_FINISH
    } state_t;

    state_t                             state_reg;
    state_t                             state_next;
    logic [tdpt_pkg::VALUE_WIDTH-1:0]   cand_reg;
    logic [tdpt_pkg::VALUE_WIDTH-1:0]   cand_next;
    logic [tdpt_pkg::VALUE_WIDTH-1:0]   d_reg;
    logic [tdpt_pkg::VALUE_WIDTH-1:0]   d_next;
    logic [tdpt_pkg::SQ_W-1:0]          sq_reg;
    logic [tdpt_pkg::SQ_W-1:0]          sq_next;
    logic                               nodiv_reg;
    logic                               nodiv_next;
    logic [tdpt_pkg::CNT_W-1:0]         fcnt_reg;
    logic [tdpt_pkg::CNT_W-1:0]         fcnt_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic                               out_nodiv_reg;
    logic                               out_nodiv_next;
    logic [tdpt_pkg::CNT_W-1:0]         out_cnt_reg;
    logic [tdpt_pkg::CNT_W-1:0]         out_cnt_next;

    logic [tdpt_pkg::VALUE_WIDTH-1:0]   cand_raw;
    logic                               in_beat;
    logic                               out_free;
    logic                               square_over;
    logic [tdpt_pkg::VALUE_WIDTH-1:0]   d_plus;
    tdpt_pkg::div_ctrl_t                div_ctrl;
    tdpt_pkg::div_stat_t                div_stat;

    assign cand_raw    = cand.candidate;
    assign cand.ready  = (state_reg == S_IDLE);
    assign in_beat     = cand.valid && cand.ready;
    assign out_free    = !out_valid_reg || res.ready;
    assign square_over = (sq_reg > {1'b0, cand_reg});
    assign d_plus      = d_reg + 1'b1;

    // Launch a trial division when the square still fits
    assign div_ctrl.start = (state_reg == S_CHECK) && !square_over;

    tdpt_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (cand_reg),
        .divisor  (d_reg),
        .stat     (div_stat)
    );

    // Sequence the divisor search
    always_comb
    begin
        state_next     = state_reg;
        cand_next      = cand_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        nodiv_next     = nodiv_reg;
        fcnt_next      = fcnt_reg;
        out_valid_next = out_valid_reg;
        out_nodiv_next = out_nodiv_reg;
        out_cnt_next   = out_cnt_reg;

        // Drop the result once taken
        if (res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    cand_next = cand_raw;
                    d_next    = tdpt_pkg::FIRST_DIVISOR;
                    sq_next   = tdpt_pkg::FIRST_SQUARE;
                    if (cand_raw[tdpt_pkg::VALUE_WIDTH-1] ||
                        (cand_raw <= tdpt_pkg::FIRST_DIVISOR))
                    begin
                        nodiv_next = 1'b1;
                        fcnt_next  = tdpt_pkg::FIRST_DIVISOR[tdpt_pkg::CNT_W-1:0];
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (square_over)
                begin
                    nodiv_next = 1'b1;
                    fcnt_next  = cand_reg[tdpt_pkg::CNT_W-1:0];
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_DIVIDE;
                end
            end
            S_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    if (div_stat.rem_zero)
                    begin
                        nodiv_next = 1'b0;
                        fcnt_next  = d_plus[tdpt_pkg::CNT_W-1:0];
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        d_next     = d_plus;
                        sq_next    = sq_reg + {d_reg, 1'b1};
                        state_next = S_CHECK;
                    end
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_nodiv_next = nodiv_reg;
                    out_cnt_next   = fcnt_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg      <= cand_next;
        d_reg         <= d_next;
        sq_reg        <= sq_next;
        nodiv_reg     <= nodiv_next;
        fcnt_reg      <= fcnt_next;
        out_nodiv_reg <= out_nodiv_next;
        out_cnt_reg   <= out_cnt_next;
    end

    assign res.valid         = out_valid_reg;
    assign res.no_divisor    = out_nodiv_reg;
    assign res.final_counter = out_cnt_reg;

    // The remainder unit reports only during a trial
    a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIVIDE))
        else $error("remainder done outside divide state");

    // Negative candidates skip the search; small ones take the same path
    a_short_path: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && cand_raw[tdpt_pkg::VALUE_WIDTH-1]) |=>
            (state_reg == S_FINISH) && nodiv_reg)
        else $error("negative candidate entered the search");

    // A found divisor reports at least three
    a_found_counter: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FINISH) && !nodiv_reg) |->
            (fcnt_reg >= tdpt_pkg::CNT_W'(3)))
        else $error("found divisor counter below three");

    // A finished search loads the result register when it frees
    a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FINISH) && out_free) |=>
            res.valid && (res.no_divisor == $past(nodiv_reg)))
        else $error("result not loaded from finished search");

endmodule

`default_nettype wire

### src/tdpt_rem.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module tdpt_rem (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire tdpt_pkg::div_ctrl_t                ctrl,
    input  wire logic [tdpt_pkg::VALUE_WIDTH-1:0]   dividend,
    input  wire logic [tdpt_pkg::VALUE_WIDTH-1:0]   divisor,
    output tdpt_pkg::div_stat_t                     stat
);

    logic [tdpt_pkg::VALUE_WIDTH-1:0] dvd_reg;
    logic [tdpt_pkg::VALUE_WIDTH-1:0] dvd_next;
    logic [tdpt_pkg::VALUE_WIDTH-1:0] rem_reg;
    logic [tdpt_pkg::VALUE_WIDTH-1:0] rem_next;
    logic [tdpt_pkg::BIT_W-1:0]       cnt_reg;
    logic [tdpt_pkg::BIT_W-1:0]       cnt_next;
    logic                             busy_reg;
    logic                             busy_next;
    logic                             done_reg;
    logic                             done_next;
    logic                             zero_reg;
    logic                             zero_next;
    logic [tdpt_pkg::VALUE_WIDTH-1:0] trial;
    logic                             last_bit;

    // Shift the next dividend bit into the partial remainder
    assign trial    = {rem_reg[tdpt_pkg::VALUE_WIDTH-2:0], dvd_reg[tdpt_pkg::VALUE_WIDTH-1]};
    assign last_bit = (cnt_reg == tdpt_pkg::BIT_W'(tdpt_pkg::VALUE_WIDTH - 1));

    // Step the restoring division
    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        zero_next = zero_reg;
        if (ctrl.start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[tdpt_pkg::VALUE_WIDTH-2:0], 1'b0};
            rem_next = (trial >= divisor) ? (trial - divisor) : trial;
            cnt_next = cnt_reg + 1'b1;
            if (last_bit)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                zero_next = (rem_next == '0);
            end
        end
    end

    // Hold control state under reset, datapath free-running
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        zero_reg <= zero_next;
    end

    assign stat.done     = done_reg;
    assign stat.rem_zero = zero_reg;

endmodule

`default_nettype wire
